@@ src/pgrd_pkg.sv @@
`timescale 1ns / 1ps

package pgrd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_DYN_F        = 2'd0;
    localparam logic [1:0] REG_START_BLACK  = 2'd1;
    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

    localparam int CFG_DATA_W = 7;

    // Special nybble codes and raw-bitmap selection.
    localparam logic [3:0] NYB_REPEAT     = 4'd14;
    localparam logic [3:0] NYB_ONE_REPEAT = 4'd15;
    localparam logic [3:0] DYN_F_RAW      = 4'd14;

    localparam logic [3:0] ZERO_COUNT_MAX = 4'hf;
    localparam logic [6:0] REPEAT_MAX     = 7'd127;
    localparam int         RUN_BIAS       = 193;

    localparam logic [2:0] BIT_FIRST = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       nyb;
        logic       lo;
        logic       raw_load;
        logic [2:0] bit_idx;
        logic       run_step;
        logic       emit;
        logic       err_emit;
    } pgrd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic raw;
        logic nyb_run;
        logic nyb_err;
        logic row_full;
        logic len_nz;
        logic emit_more;
        logic emit_last;
        logic out_free;
    } pgrd_status_t;

endpackage

@@ src/pk_glyph_raster_decoder.sv @@
`timescale 1ns / 1ps

// Decodes one PK glyph raster, fed one byte per transaction, into pixel rows.
// With dyn_f below 14 each byte is read as two nybbles of packed run counts
// (high nybble first), with 14 or 15 setting a repeat count for the row in
// which the next run ends; with dyn_f of 14 or 15 the bytes are a raw bitmap,
// MSB first. Each finished row leaves as one transaction, followed by its
// repeated copies; the last row, or a double repeat count (error_code 1),
// carries last_row and ends the glyph, after which bytes are taken and
// ignored until a register write starts a new glyph. Steps: a byte is first
// taken, then in packed mode each nybble is decoded and each row segment a run
// covers is filled in turn, and in raw mode each bit is loaded and then placed;
// each finished row is then emitted, waiting while the output is stalled. The
// run sequencer handles one step per cycle. A finished row waits in the output
// register, so the next byte is taken while it is still unclaimed.

module pk_glyph_raster_decoder import pgrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            raster_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MAX_WIDTH-1:0]  row_pixels,
    output logic [5:0]            row_index,
    output logic                  last_row,
    output logic                  error_code
);

    pgrd_cmd_t    cmd;
    pgrd_status_t st;

    // The controller sequences nybbles, bits, run segments and row emission.
    pgrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the decoder state, the row buffer and the output register.
    pgrd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .raster_byte (raster_byte),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .row_pixels  (row_pixels),
        .row_index   (row_index),
        .last_row    (last_row),
        .error_code  (error_code)
    );

endmodule

@@ src/pgrd_ctrl.sv @@
`timescale 1ns / 1ps

module pgrd_ctrl import pgrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  pgrd_status_t st,
    output pgrd_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NYB  = 3'd1;
    localparam logic [2:0] S_RAW  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       lo_sel_reg, lo_sel_next;
    logic [2:0] bit_idx_reg, bit_idx_next;

    logic       adv_more;
    logic [2:0] adv_state;

    assign in_stall  = (state_reg != S_IDLE);
    assign adv_more  = st.raw ? (bit_idx_reg != 3'd0) : !lo_sel_reg;
    assign adv_state = st.raw ? S_RAW : S_NYB;

    always_comb
    begin
        state_next   = state_reg;
        lo_sel_next  = lo_sel_reg;
        bit_idx_next = bit_idx_reg;
        cmd          = '0;
        cmd.lo       = lo_sel_reg;
        cmd.bit_idx  = bit_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!st.done)
                    begin
                        if (st.raw)
                        begin
                            state_next   = S_RAW;
                            bit_idx_next = BIT_FIRST;
                        end
                        else
                        begin
                            state_next  = S_NYB;
                            lo_sel_next = 1'b0;
                        end
                    end
                end
            end
            S_NYB:
            begin
                cmd.nyb = 1'b1;
                if (st.nyb_err)
                    state_next = S_ERR;
                else if (st.nyb_run)
                    state_next = S_RUN;
                else if (adv_more && !st.done)
                begin
                    state_next  = adv_state;
                    lo_sel_next = 1'b1;
                end
                else
                    state_next = S_IDLE;
            end
            S_RAW:
            begin
                cmd.raw_load = 1'b1;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                cmd.run_step = 1'b1;
                if (st.row_full)
                    state_next = S_EMIT;
                else if (adv_more && !st.done)
                begin
                    state_next = adv_state;
                    if (st.raw)
                        bit_idx_next = bit_idx_reg - 3'd1;
                    else
                        lo_sel_next = 1'b1;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.emit_more)
                        state_next = S_EMIT;
                    else if (st.emit_last)
                        state_next = S_IDLE;
                    else if (st.len_nz)
                        state_next = S_RUN;
                    else if (adv_more)
                    begin
                        state_next = adv_state;
                        if (st.raw)
                            bit_idx_next = bit_idx_reg - 3'd1;
                        else
                            lo_sel_next = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.err_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lo_sel_reg  <= 1'b0;
            bit_idx_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            lo_sel_reg  <= lo_sel_next;
            bit_idx_reg <= bit_idx_next;
        end
    end

endmodule

@@ src/pgrd_dp.sv @@
`timescale 1ns / 1ps

module pgrd_dp import pgrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            raster_byte,
    input  logic                  out_stall,
    input  pgrd_cmd_t             cmd,
    output pgrd_status_t          st,
    output logic                  out_valid,
    output logic [MAX_WIDTH-1:0]  row_pixels,
    output logic [5:0]            row_index,
    output logic                  last_row,
    output logic                  error_code
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_ZEROS  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    logic [3:0]           dyn_f_reg;
    logic                 start_black_reg;
    logic [5:0]           glyph_width_reg;
    logic [6:0]           glyph_height_reg;
    logic [7:0]           byte_reg;
    logic [1:0]           phase_reg;
    logic [3:0]           zero_count_reg;
    logic [31:0]          accum_reg;
    logic                 pending_reg;
    logic [6:0]           repeat_reg;
    logic                 colour_reg;
    logic [MAX_WIDTH-1:0] row_buf_reg;
    logic [CW-1:0]        column_reg;
    logic [HW-1:0]        row_count_reg;
    logic                 done_reg;
    logic [31:0]          run_len_reg;
    logic                 run_colour_reg;
    logic                 out_valid_reg;
    logic [MAX_WIDTH-1:0] out_pixels_reg;
    logic [5:0]           out_index_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;

    logic [CW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic [3:0]           nyb;
    logic [31:0]          accum_sh;
    logic [3:0]           zc_dec;
    logic [33:0]          bias_sum;
    logic [31:0]          big_v;
    logic [31:0]          first_v;
    logic                 cpl;
    logic [31:0]          cpl_v;
    logic                 nyb_err;
    logic [1:0]           phase_n;
    logic [3:0]           zc_n;
    logic [31:0]          accum_n;
    logic                 pend_set;
    logic                 rep_one;
    logic [CW-1:0]        room;
    logic [CW-1:0]        k;
    logic [CW-1:0]        col_end;
    logic [MAX_WIDTH-1:0] mask;
    logic                 row_full;
    logic [31:0]          len_after;
    logic [HW-1:0]        rc_inc;
    logic                 last_c;
    logic                 emit_more;

    function automatic logic [MAX_WIDTH-1:0] low_mask(input logic [CW-1:0] n);
        logic [MAX_WIDTH-1:0] m;
        for (int i = 0; i < MAX_WIDTH; i++)
            m[i] = (32'(i) < 32'(n));
        return m;
    endfunction

    always_comb
    begin
        if (glyph_width_reg == 6'd0)
            w_eff = CW'(1);
        else if (32'(glyph_width_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(glyph_width_reg);
        if (glyph_height_reg == 7'd0)
            h_eff = HW'(1);
        else if (32'(glyph_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(glyph_height_reg);
    end

    assign nyb      = cmd.lo ? byte_reg[3:0] : byte_reg[7:4];
    assign accum_sh = (|accum_reg[31:28]) ? '1 : {accum_reg[27:0], nyb};
    assign zc_dec   = zero_count_reg - 4'd1;
    assign bias_sum = {2'b00, accum_sh} + 34'(RUN_BIAS)
                      - 34'({dyn_f_reg, 4'b0000}) + 34'(dyn_f_reg);
    assign big_v    = (|bias_sum[33:32]) ? '1 : bias_sum[31:0];
    assign first_v  = 32'({nyb - dyn_f_reg - 4'd1, 4'b0000}) + 32'(dyn_f_reg) + 32'd1;

    // Packed-number decoding of one nybble.
    always_comb
    begin
        cpl      = 1'b0;
        cpl_v    = 32'(nyb);
        nyb_err  = 1'b0;
        phase_n  = phase_reg;
        zc_n     = zero_count_reg;
        accum_n  = accum_reg;
        pend_set = 1'b0;
        rep_one  = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (nyb == 4'd0)
                begin
                    zc_n    = 4'd1;
                    phase_n = PH_ZEROS;
                end
                else if (nyb <= dyn_f_reg)
                    cpl = 1'b1;
                else if (nyb < NYB_REPEAT)
                begin
                    accum_n = first_v;
                    phase_n = PH_SECOND;
                end
                else if (pending_reg || repeat_reg != 7'd0)
                    nyb_err = 1'b1;
                else if (nyb == NYB_ONE_REPEAT)
                    rep_one = 1'b1;
                else
                    pend_set = 1'b1;
            end
            PH_ZEROS:
            begin
                if (nyb == 4'd0)
                begin
                    if (zero_count_reg != ZERO_COUNT_MAX)
                        zc_n = zero_count_reg + 4'd1;
                end
                else
                begin
                    accum_n = 32'(nyb);
                    phase_n = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                accum_n = accum_sh;
                zc_n    = zc_dec;
                if (zc_dec == 4'd0)
                begin
                    cpl   = 1'b1;
                    cpl_v = big_v;
                end
            end
            PH_SECOND:
            begin
                cpl   = 1'b1;
                cpl_v = accum_reg + 32'(nyb);
            end
        endcase
        if (cpl)
            phase_n = PH_FIRST;
    end

    // One run segment within the current row.
    assign room      = w_eff - column_reg;
    assign k         = (run_len_reg < 32'(room)) ? run_len_reg[CW-1:0] : room;
    assign col_end   = column_reg + k;
    assign mask      = low_mask(col_end) & ~low_mask(column_reg);
    assign row_full  = (col_end >= w_eff);
    assign len_after = run_len_reg - 32'(k);

    assign rc_inc    = row_count_reg + HW'(1);
    assign last_c    = (rc_inc >= h_eff);
    assign emit_more = !last_c && (repeat_reg != 7'd0);

    always_comb
    begin
        st.done      = done_reg;
        st.raw       = (dyn_f_reg >= DYN_F_RAW);
        st.nyb_run   = cpl && !pending_reg;
        st.nyb_err   = nyb_err;
        st.row_full  = row_full;
        st.len_nz    = (run_len_reg != 32'd0);
        st.emit_more = emit_more;
        st.emit_last = last_c;
        st.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_f_reg        <= 4'd0;
            start_black_reg  <= 1'b0;
            glyph_width_reg  <= 6'd32;
            glyph_height_reg <= 7'd64;
            byte_reg         <= 8'd0;
            phase_reg        <= PH_FIRST;
            zero_count_reg   <= 4'd0;
            accum_reg        <= 32'd0;
            pending_reg      <= 1'b0;
            repeat_reg       <= 7'd0;
            colour_reg       <= 1'b0;
            row_buf_reg      <= '0;
            column_reg       <= '0;
            row_count_reg    <= '0;
            done_reg         <= 1'b0;
            run_len_reg      <= 32'd0;
            run_colour_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pixels_reg   <= '0;
            out_index_reg    <= 6'd0;
            out_last_reg     <= 1'b0;
            out_err_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                byte_reg <= raster_byte;

            if (cmd.nyb)
            begin
                phase_reg      <= phase_n;
                zero_count_reg <= zc_n;
                accum_reg      <= accum_n;
                if (pend_set)
                    pending_reg <= 1'b1;
                if (rep_one)
                    repeat_reg <= 7'd1;
                if (cpl)
                begin
                    if (pending_reg)
                    begin
                        repeat_reg  <= (cpl_v > 32'(REPEAT_MAX)) ? REPEAT_MAX : cpl_v[6:0];
                        pending_reg <= 1'b0;
                    end
                    else
                    begin
                        run_len_reg    <= cpl_v;
                        run_colour_reg <= colour_reg;
                        colour_reg     <= ~colour_reg;
                    end
                end
            end

            if (cmd.raw_load)
            begin
                run_len_reg    <= 32'd1;
                run_colour_reg <= byte_reg[cmd.bit_idx];
            end

            if (cmd.run_step)
            begin
                if (run_colour_reg)
                    row_buf_reg <= row_buf_reg | mask;
                column_reg  <= col_end;
                run_len_reg <= len_after;
            end

            if (cmd.emit)
            begin
                out_pixels_reg <= row_buf_reg;
                out_index_reg  <= 6'(row_count_reg);
                out_last_reg   <= last_c;
                out_err_reg    <= 1'b0;
                row_count_reg  <= rc_inc;
                if (last_c)
                    done_reg <= 1'b1;
                if (emit_more)
                    repeat_reg <= repeat_reg - 7'd1;
                else
                begin
                    row_buf_reg <= '0;
                    column_reg  <= '0;
                end
            end

            if (cmd.err_emit)
            begin
                out_pixels_reg <= '0;
                out_index_reg  <= 6'(row_count_reg);
                out_last_reg   <= 1'b1;
                out_err_reg    <= 1'b1;
                done_reg       <= 1'b1;
            end

            if (cmd.emit || cmd.err_emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // Any register write restarts the glyph.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DYN_F:        dyn_f_reg        <= cfg_data[3:0];
                    REG_START_BLACK:  start_black_reg  <= cfg_data[0];
                    REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[5:0];
                    REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[6:0];
                endcase
                phase_reg      <= PH_FIRST;
                zero_count_reg <= 4'd0;
                accum_reg      <= 32'd0;
                pending_reg    <= 1'b0;
                repeat_reg     <= 7'd0;
                colour_reg     <= (cfg_index == REG_START_BLACK) ? cfg_data[0]
                                                                 : start_black_reg;
                row_buf_reg    <= '0;
                column_reg     <= '0;
                row_count_reg  <= '0;
                done_reg       <= 1'b0;
                run_len_reg    <= 32'd0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_pixels = out_pixels_reg;
    assign row_index  = out_index_reg;
    assign last_row   = out_last_reg;
    assign error_code = out_err_reg;

endmodule

@@ src/pgrd_checker.sv @@
`timescale 1ns / 1ps

module pgrd_checker
#(
    parameter int MAX_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [MAX_WIDTH-1:0]  row_pixels,
    input logic [5:0]            row_index,
    input logic                  last_row,
    input logic                  error_code
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_pixels)
            && $stable(row_index) && $stable(last_row) && $stable(error_code))
        else $error("stalled result changed");

    // An error result is an empty final row.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code |-> last_row && (row_pixels == '0))
        else $error("malformed error result");

    // A new result only appears while a byte is being decoded.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind pk_glyph_raster_decoder pgrd_checker #(.MAX_WIDTH(MAX_WIDTH)) u_pgrd_checker (.*);
